FILE: rtl/core/grss_pkg.sv
// Shared types, constants and helper functions for the gyro rate scaler.
// Used by grss_lane, grss_merge and gyro_rate_scale_and_smooth; no dependencies.
`default_nettype none

package grss_pkg;

  // Number of samples averaged to seed the filter after reset or recalibration.
  localparam int CAL_SAMPLES = 10;

  // Rounding offset and reciprocal for the division by CAL_SAMPLES.
  localparam int CAL_HALF = CAL_SAMPLES / 2;
  localparam int CAL_SHIFT = 31;
  localparam logic [63:0] CAL_RECIP_FULL =
    ((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [31:0] CAL_RECIP = CAL_RECIP_FULL[31:0];

  // Resolutions in unsigned Q0.32 radians per second per LSB.
  localparam logic [23:0] RES_250  = 24'd1311823;
  localparam logic [23:0] RES_500  = 24'd2623646;
  localparam logic [23:0] RES_2000 = 24'd10494585;

  localparam logic [16:0] COEFF_ONE = 17'd65536;
  localparam logic signed [23:0] Q24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] Q24_MIN = -24'sh800000;

  // Request codes.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_RECAL  = 1'b1;

  // Register indexes.
  localparam logic [1:0] REG_RANGE = 2'd0;
  localparam logic [1:0] REG_COEFF = 2'd1;

  // Range codes.
  localparam logic [1:0] RANGE_250  = 2'd0;
  localparam logic [1:0] RANGE_500  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_PREP,
    ST_PROD,
    ST_UPD
  } grss_state_t;

  // Control from the sequencer to every lane.
  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
    logic seeding;
  } grss_lane_ctl_t;

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic signed [23:0] rate;
    logic signed [23:0] smooth;
  } grss_lane_res_t;

  // Resolution chosen by the range code; the unused code falls to 2000 dps.
  function automatic logic [23:0] range_res(input logic [1:0] code);
    logic [23:0] res;
    unique case (code)
      RANGE_250: res = RES_250;
      RANGE_500: res = RES_500;
      default:   res = RES_2000;
    endcase
    return res;
  endfunction

  // Clamp a wide signed value to the signed 24-bit range.
  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'(Q24_MAX)) begin
      r = Q24_MAX;
    end else if (v < 28'(Q24_MIN)) begin
      r = Q24_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gyro_rate_scale_and_smooth.sv
// Top level of the gyro rate scaler: configuration, sequencer, three lanes, merge.
// Depends on grss_pkg, grss_lane and grss_merge.
`default_nettype none

// A sample transaction is not followed by another until it is through:
// five stages run through the lanes (scale multiply, rounding, difference, filter
// or seeding multiply, state update), and the sequencer takes one sample at a
// time because each update needs the filter state left by the one before. The
// update stage waits while a previous result is still held and stalled in the
// output register. A recalibrate transaction, taken while idle, gives no result;
// the first CAL_SAMPLES samples after reset or recalibration only seed the filter
// with their average and give no result. Configuration is taken on any cycle
// and must only be written while the block is idle.
module gyro_rate_scale_and_smooth
  import grss_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration write channel.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [16:0]  cfg_data,
  // Input channel.
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         in_req_type,
  input  wire logic [7:0]   in_x_high,
  input  wire logic [7:0]   in_x_low,
  input  wire logic [7:0]   in_y_high,
  input  wire logic [7:0]   in_y_low,
  input  wire logic [7:0]   in_z_high,
  input  wire logic [7:0]   in_z_low,
  // Result channel.
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic signed [23:0] out_rate_x,
  output logic signed [23:0] out_rate_y,
  output logic signed [23:0] out_rate_z,
  output logic signed [23:0] out_smooth_x,
  output logic signed [23:0] out_smooth_y,
  output logic signed [23:0] out_smooth_z
);

  grss_state_t    state_r;
  grss_state_t    state_nxt;
  logic [1:0]     range_sel_r;
  logic [16:0]    coeff_r;
  logic [7:0]     seed_cnt_r;
  logic [7:0]     seed_cnt_nxt;
  logic           seeding_r;
  logic           in_accept;
  logic           out_free;
  logic           out_load;
  logic [16:0]    coeff_eff;
  logic [23:0]    res;
  grss_lane_ctl_t ctl;
  grss_lane_res_t lane_res [3];
  logic [7:0]     lane_high [3];
  logic [7:0]     lane_low [3];

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_sel_r <= RANGE_250;
      coeff_r     <= COEFF_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RANGE: range_sel_r <= cfg_data[1:0];
        REG_COEFF: coeff_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign res       = range_res(range_sel_r);
  assign coeff_eff = (coeff_r > COEFF_ONE) ? COEFF_ONE : coeff_r;

  // The input is only taken while the sequencer is idle.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && in_req_type == REQ_SAMPLE) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_UPD;
      ST_UPD: begin
        if (seeding_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctl.load    = in_accept && in_req_type == REQ_SAMPLE;
    ctl.clear   = in_accept && in_req_type == REQ_RECAL;
    ctl.seeding = seeding_r;
    ctl.commit  = (state_r == ST_UPD) && (seeding_r || out_free);
    out_load    = (state_r == ST_UPD) && !seeding_r && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Seeding counter and the per-sample seeding flag.
  always_comb begin
    seed_cnt_nxt = seed_cnt_r;
    if (ctl.clear) begin
      seed_cnt_nxt = '0;
    end else if (ctl.commit && seeding_r) begin
      seed_cnt_nxt = seed_cnt_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_cnt_r <= '0;
      seeding_r  <= 1'b0;
    end else begin
      seed_cnt_r <= seed_cnt_nxt;
      if (ctl.load) begin
        seeding_r <= (seed_cnt_r < 8'(CAL_SAMPLES));
      end
    end
  end

  // One lane per axis.
  assign lane_high[0] = in_x_high;
  assign lane_low[0]  = in_x_low;
  assign lane_high[1] = in_y_high;
  assign lane_low[1]  = in_y_low;
  assign lane_high[2] = in_z_high;
  assign lane_low[2]  = in_z_low;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    grss_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .data_high (lane_high[g]),
      .data_low  (lane_low[g]),
      .res       (res),
      .coeff     (coeff_eff),
      .result    (lane_res[g])
    );
  end

  // Output register.
  grss_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (out_load),
    .lane_res     (lane_res),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rate_x   (out_rate_x),
    .out_rate_y   (out_rate_y),
    .out_rate_z   (out_rate_z),
    .out_smooth_x (out_smooth_x),
    .out_smooth_y (out_smooth_y),
    .out_smooth_z (out_smooth_z)
  );

  // A result only appears after the update stage of a non-seeding sample.
  a_out_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_UPD) && !$past(seeding_r))
    else $error("result appeared outside the update stage");

  // The seeding counter stops at the calibration length.
  a_seed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seed_cnt_r <= 8'(CAL_SAMPLES))
    else $error("seeding counter overran");

  // A recalibrate transaction restarts seeding and leaves the sequencer idle.
  a_recal: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_req_type == REQ_RECAL) |=> (state_r == ST_IDLE && seed_cnt_r == 8'd0))
    else $error("recalibration did not restart seeding");

  // The filter state only moves in the update stage.
  a_commit_stage: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (state_r == ST_UPD && !in_accept))
    else $error("filter commit outside the update stage");

endmodule

`default_nettype wire

FILE: rtl/core/grss_lane.sv
// One axis lane: byte join, range scaling, seeding average and filter update.
// Depends on grss_pkg for constants, control and result types.
`default_nettype none

module grss_lane
  import grss_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire grss_lane_ctl_t ctl,
  input  wire logic [7:0]     data_high,
  input  wire logic [7:0]     data_low,
  input  wire logic [23:0]    res,
  input  wire logic [16:0]    coeff,
  output grss_lane_res_t      result
);

  logic signed [15:0] raw_r;
  logic signed [40:0] scale_r;
  logic signed [23:0] rate_r;
  logic signed [24:0] diff_r;
  logic [24:0]        absx_r;
  logic               neg_r;
  logic signed [42:0] fprod_r;
  logic [56:0]        qprod_r;
  logic signed [23:0] state_r;
  logic signed [23:0] state_nxt;

  logic signed [40:0] scale_rnd;
  logic signed [40:0] scale_shr;
  logic [23:0]        rate_abs;
  logic signed [42:0] fprod_rnd;
  logic signed [42:0] fprod_shr;
  logic [23:0]        quot;
  logic signed [24:0] seed_delta;
  logic signed [27:0] sum;

  // Capture the raw sample when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      raw_r <= $signed({data_high, data_low});
    end
  end

  // Scale by the selected resolution.
  always_ff @(posedge clk) begin
    scale_r <= raw_r * $signed({1'b0, res});
  end

  // Round half up to Q7.16 and saturate.
  assign scale_rnd = scale_r + 41'sd32768;
  assign scale_shr = scale_rnd >>> 16;

  always_ff @(posedge clk) begin
    rate_r <= sat24(scale_shr[27:0]);
  end

  // Prepare the filter difference and the magnitude for the seeding divide.
  assign rate_abs = rate_r[23] ? 24'(-rate_r) : 24'(rate_r);

  always_ff @(posedge clk) begin
    diff_r <= 25'(rate_r) - 25'(state_r);
    absx_r <= 25'(rate_abs) + 25'(CAL_HALF);
    neg_r  <= rate_r[23];
  end

  // Both products; the sequencer decides which one is committed.
  always_ff @(posedge clk) begin
    fprod_r <= $signed({1'b0, coeff}) * diff_r;
    qprod_r <= absx_r * CAL_RECIP;
  end

  // New filter state: seeding adds rate / CAL_SAMPLES, otherwise the weighted step.
  assign quot       = 24'(qprod_r >> CAL_SHIFT);
  assign seed_delta = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign fprod_rnd  = fprod_r + 43'sd32768;
  assign fprod_shr  = fprod_rnd >>> 16;

  always_comb begin
    if (ctl.seeding) begin
      sum = 28'(state_r) + 28'(seed_delta);
    end else begin
      sum = 28'(state_r) + fprod_shr[27:0];
    end
    state_nxt = sat24(sum);
  end

  // Filter state register.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      state_r <= '0;
    end else if (ctl.commit) begin
      state_r <= state_nxt;
    end
  end

  assign result.rate   = rate_r;
  assign result.smooth = state_nxt;

endmodule

`default_nettype wire

FILE: rtl/core/grss_merge.sv
// Merging stage: gathers the three lane results into the output register.
// Depends on grss_pkg for the lane result type.
`default_nettype none

module grss_merge
  import grss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire grss_lane_res_t   lane_res [3],
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic signed [23:0]    out_rate_x,
  output logic signed [23:0]    out_rate_y,
  output logic signed [23:0]    out_rate_z,
  output logic signed [23:0]    out_smooth_x,
  output logic signed [23:0]    out_smooth_y,
  output logic signed [23:0]    out_smooth_z
);

  logic               out_valid_r;
  logic               out_valid_nxt;
  grss_lane_res_t     res_r [3];

  // The register may be refilled once its current transaction is taken.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload capture from all lanes at once.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= lane_res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rate_x   = res_r[0].rate;
  assign out_rate_y   = res_r[1].rate;
  assign out_rate_z   = res_r[2].rate;
  assign out_smooth_x = res_r[0].smooth;
  assign out_smooth_y = res_r[1].smooth;
  assign out_smooth_z = res_r[2].smooth;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for gyro_rate_scale_and_smooth: directed corner samples, then random
// phases that cover every range code and filter weights from zero up past one, with random gaps on both channels.
// Depends on grss_pkg and the gyro_rate_scale_and_smooth RTL.
`default_nettype none

module tb;
  import grss_pkg::*;

  // Range codes and register indexes that the package does not name.
  localparam logic [1:0] RANGE_2000   = 2'd2;
  localparam logic [1:0] RANGE_SPARE  = 2'd3;
  localparam logic [1:0] REG_UNUSED_A = 2'd2;
  localparam logic [1:0] REG_UNUSED_B = 2'd3;

  // Resolutions in Q0.32 radians per second per LSB.
  localparam longint SCALE_250  = 64'd1311823;
  localparam longint SCALE_500  = 64'd2623646;
  localparam longint SCALE_2000 = 64'd10494585;
  localparam longint WEIGHT_ONE = 64'd65536;

  localparam int SETTLE_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 10;
  localparam int CHUNK_ITEMS = 60;

  typedef struct {
    logic       req_type;
    logic [7:0] x_high, x_low, y_high, y_low, z_high, z_low;
  } gyro_item_t;

  typedef struct {
    logic signed [23:0] rate_x, rate_y, rate_z;
    logic signed [23:0] smooth_x, smooth_y, smooth_z;
  } smoothed_rates_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_RANGE;
  logic [16:0] cfg_data = '0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_req_type = REQ_SAMPLE;
  logic [7:0] in_x_high = '0, in_x_low = '0, in_y_high = '0;
  logic [7:0] in_y_low = '0, in_z_high = '0, in_z_low = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [23:0] out_rate_x, out_rate_y, out_rate_z;
  logic signed [23:0] out_smooth_x, out_smooth_y, out_smooth_z;

  // Mirror of the block's registers and filter state.
  logic [1:0]         range_sel = RANGE_250;
  logic [16:0]        filter_weight = 17'd65536;
  logic signed [23:0] filtered [3] = '{24'sd0, 24'sd0, 24'sd0};
  int                 seed_count = 0;

  gyro_item_t      queued_samples [$];
  smoothed_rates_t pending_rates [$];

  int  mismatches = 0;
  int  hold_off = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  quiet_sender = 1'b0;
  bit  quiet_receiver = 1'b0;

  gyro_rate_scale_and_smooth uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_x_high    (in_x_high),
    .in_x_low     (in_x_low),
    .in_y_high    (in_y_high),
    .in_y_low     (in_y_low),
    .in_z_high    (in_z_high),
    .in_z_low     (in_z_low),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rate_x   (out_rate_x),
    .out_rate_y   (out_rate_y),
    .out_rate_z   (out_rate_z),
    .out_smooth_x (out_smooth_x),
    .out_smooth_y (out_smooth_y),
    .out_smooth_z (out_smooth_z)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp to the signed 24-bit range.
  function automatic logic signed [23:0] clamp_q24(input longint v);
    if (v > longint'(Q24_MAX)) begin
      return Q24_MAX;
    end else if (v < longint'(Q24_MIN)) begin
      return Q24_MIN;
    end
    return v[23:0];
  endfunction

  // Join two bytes into a signed raw rate and scale it to Q7.16, rounding half up.
  function automatic logic signed [23:0] scale_raw(input logic [7:0] hi, input logic [7:0] lo);
    longint raw;
    longint res;
    raw = longint'($signed({hi, lo}));
    case (range_sel)
      RANGE_250: res = SCALE_250;
      RANGE_500: res = SCALE_500;
      default:   res = SCALE_2000;
    endcase
    return clamp_q24((raw * res + 64'sd32768) >>> 16);
  endfunction

  // One calibration sample's share of the seed: v / CAL_SAMPLES, ties away from zero.
  function automatic longint seed_share(input longint v);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (2 * mag + CAL_SAMPLES) / (2 * CAL_SAMPLES);
    return (v < 0) ? -q : q;
  endfunction

  // Advance the mirrored filter by one accepted transaction and queue any result it gives.
  task automatic advance_filter(input gyro_item_t it);
    logic signed [23:0] rate [3];
    longint weight;
    longint diff;
    smoothed_rates_t res;
    if (it.req_type == REQ_RECAL) begin
      for (int i = 0; i < 3; i++) filtered[i] = '0;
      seed_count = 0;
    end else begin
      rate[0] = scale_raw(it.x_high, it.x_low);
      rate[1] = scale_raw(it.y_high, it.y_low);
      rate[2] = scale_raw(it.z_high, it.z_low);
      if (seed_count < CAL_SAMPLES) begin
        for (int i = 0; i < 3; i++) begin
          filtered[i] = clamp_q24(longint'(filtered[i]) + seed_share(longint'(rate[i])));
        end
        seed_count++;
      end else begin
        weight = (longint'(filter_weight) > WEIGHT_ONE) ? WEIGHT_ONE : longint'(filter_weight);
        for (int i = 0; i < 3; i++) begin
          diff = longint'(rate[i]) - longint'(filtered[i]);
          filtered[i] = clamp_q24(longint'(filtered[i]) + ((weight * diff + 64'sd32768) >>> 16));
        end
        res.rate_x = rate[0];
        res.rate_y = rate[1];
        res.rate_z = rate[2];
        res.smooth_x = filtered[0];
        res.smooth_y = filtered[1];
        res.smooth_z = filtered[2];
        pending_rates.push_back(res);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic signed [23:0] want,
                               input logic signed [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Gap before the next transaction: mostly none or short, now and then long.
  function automatic int draw_gap(input bit quiet);
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [7:0] pick_high_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_low_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly samples with random content; an occasional recalibration breaks the stream.
  function automatic gyro_item_t random_item();
    gyro_item_t it;
    it.req_type = ($urandom_range(0, 49) == 0) ? REQ_RECAL : REQ_SAMPLE;
    it.x_high = pick_high_byte();
    it.x_low = pick_low_byte();
    it.y_high = pick_high_byte();
    it.y_low = pick_low_byte();
    it.z_high = pick_high_byte();
    it.z_low = pick_low_byte();
    return it;
  endfunction

  // Raw values at the ends and across the sign boundary, rotated between the axes.
  function automatic gyro_item_t corner_item(input logic req, input int k);
    logic [15:0] corners [8];
    gyro_item_t it;
    corners = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                16'h0000, 16'h8001, 16'h7F00, 16'h00FF};
    it.req_type = req;
    {it.x_high, it.x_low} = corners[k % 8];
    {it.y_high, it.y_low} = corners[(k + 3) % 8];
    {it.z_high, it.z_low} = corners[(k + 5) % 8];
    return it;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_RANGE) begin
      range_sel = value[1:0];
    end else if (idx == REG_COEFF) begin
      filter_weight = value;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every queued sample is taken and every expected result has arrived.
  task automatic wait_drained();
    do @(posedge clk);
    while (queued_samples.size() != 0 || in_valid || pending_rates.size() != 0);
  endtask

  // Driver: presents queued samples, holds each until taken, predicts on acceptance.
  always @(posedge clk) begin
    gyro_item_t taken;
    gyro_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      hold_off = 0;
    end else begin
      if (in_valid && !in_stall) begin
        taken.req_type = in_req_type;
        taken.x_high = in_x_high;
        taken.x_low = in_x_low;
        taken.y_high = in_y_high;
        taken.y_low = in_y_low;
        taken.z_high = in_z_high;
        taken.z_low = in_z_low;
        advance_filter(taken);
      end
      if (!in_valid || !in_stall) begin
        if (hold_off > 0) begin
          hold_off--;
          in_valid <= 1'b0;
        end else if (queued_samples.size() != 0) begin
          nxt = queued_samples.pop_front();
          in_req_type <= nxt.req_type;
          in_x_high <= nxt.x_high;
          in_x_low <= nxt.x_low;
          in_y_high <= nxt.y_high;
          in_y_low <= nxt.y_low;
          in_z_high <= nxt.z_high;
          in_z_low <= nxt.z_low;
          in_valid <= 1'b1;
          hold_off = draw_gap(quiet_sender);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation, stalls at random.
  always @(posedge clk) begin
    smoothed_rates_t want;
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_rates.size() == 0) begin
          $error("result transaction with no sample waiting for it");
          mismatches++;
        end else begin
          want = pending_rates.pop_front();
          compare_field("rate_x", want.rate_x, out_rate_x);
          compare_field("rate_y", want.rate_y, out_rate_y);
          compare_field("rate_z", want.rate_z, out_rate_z);
          compare_field("smooth_x", want.smooth_x, out_smooth_x);
          compare_field("smooth_y", want.smooth_y, out_smooth_y);
          compare_field("smooth_z", want.smooth_z, out_smooth_z);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (quiet_receiver) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
        end else if (r < 95) begin
          stall_left = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(10, 40);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when no channel has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[gyro_rate_scale_and_smooth] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: directed corners under reset settings, then random phases.
  initial begin
    logic [1:0]  code;
    logic [16:0] weight_val;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Calibration cut short by a recalibration, a full calibration, then filtered samples.
    for (int k = 0; k < 8; k++) queued_samples.push_back(corner_item(REQ_SAMPLE, k));
    queued_samples.push_back(corner_item(REQ_RECAL, 1));
    for (int k = 0; k < 10; k++) queued_samples.push_back(corner_item(REQ_SAMPLE, k + 2));
    for (int k = 0; k < 5; k++) queued_samples.push_back(corner_item(REQ_SAMPLE, k));
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin code = RANGE_500;   weight_val = 17'd0;      end
        1: begin code = RANGE_2000;  weight_val = 17'd1;      end
        2: begin code = RANGE_SPARE; weight_val = 17'd65535;  end
        3: begin code = RANGE_2000;  weight_val = 17'h1FFFF;  end
        4: begin code = RANGE_250;   weight_val = 17'd65537;  end
        5: begin code = RANGE_250;   weight_val = 17'd32768;  end
        default: begin
          code = 2'($urandom_range(0, 3));
          case ($urandom_range(0, 3))
            0: weight_val = 17'($urandom_range(0, 4096));
            1: weight_val = 17'($urandom_range(65536, 131071));
            default: weight_val = 17'($urandom_range(0, 65536));
          endcase
        end
      endcase
      // Upper bits of the range write are junk that the block must drop.
      write_reg(REG_RANGE, {15'($urandom_range(0, 32767)), code});
      write_reg(REG_COEFF, weight_val);
      write_reg((ph % 2 == 0) ? REG_UNUSED_A : REG_UNUSED_B, 17'($urandom_range(0, 131071)));
      quiet_sender = (ph % 4 == 2);
      quiet_receiver = (ph % 4 == 2) || (ph % 5 == 3);
      // The sender pauses between the two halves until every result is back.
      for (int half = 0; half < 2; half++) begin
        for (int k = 0; k < CHUNK_ITEMS; k++) queued_samples.push_back(random_item());
        wait_drained();
      end
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (mismatches == 0 && pending_rates.size() == 0) begin
      $display("[gyro_rate_scale_and_smooth] OK");
    end else begin
      $display("[gyro_rate_scale_and_smooth] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
